/* rtl/core/ihf_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header filter package
// Types, codes and constants that the filter modules share.
// ----------------------------------------------------------------------------
package ihf_pkg;

   // Header and protocol constants.
   localparam logic [15:0] HDR_MIN_LEN  = 16'd20;
   localparam logic [7:0]  PROTO_ICMP   = 8'd1;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [31:0] BCAST_ALL    = 32'hFFFF_FFFF;
   localparam logic [15:0] FRAG_MASK    = 16'h3FFF;
   localparam logic [15:0] SUM_GOOD     = 16'hFFFF;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
   localparam logic [3:0]  VERSION_FOUR = 4'd4;
   localparam logic [3:0]  IHL_MIN      = 4'd5;

   // Configuration register layout.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        CSR_IDX_HOST_ADDR = 1'b0;
   localparam logic        CSR_IDX_NETMASK   = 1'b1;

   // Verdict codes.
   typedef enum logic [3:0] {
      VERDICT_ICMP        = 4'd0,
      VERDICT_UDP         = 4'd1,
      VERDICT_TCP         = 4'd2,
      VERDICT_NO_HANDLER  = 4'd3,
      VERDICT_SHORT       = 4'd4,
      VERDICT_VERSION_IHL = 4'd5,
      VERDICT_HDR_PAST    = 4'd6,
      VERDICT_TOTLEN      = 4'd7,
      VERDICT_FRAGMENT    = 4'd8,
      VERDICT_CHECKSUM    = 4'd9,
      VERDICT_NOT_ADDR    = 4'd10,
      VERDICT_NOT_LOCAL   = 4'd11
   } verdict_type;

   // Input transfer: one packet byte with its last-byte mark.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Result transfer: one verdict per packet.
   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [5:0]  header_len;
      logic [15:0] body_len;
   } rsp_type;

   // Per-packet header state captured while bytes arrive.
   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] header_sum;
      logic [7:0]  held_byte;
      logic [7:0]  version_ihl;
      logic [15:0] total_len;
      logic [15:0] frag;
      logic [7:0]  proto;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
   } pkt_fields_type;

   // Configuration register values.
   typedef struct packed {
      logic [31:0] host_addr;
      logic [31:0] netmask;
   } cfg_type;

endpackage

/* rtl/core/ipv4_receive_header_filter_unit.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header filter
// Validates an IPv4 header byte by byte and gives one verdict per packet.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one packet byte per transfer with a last-byte mark;
// a byte can be taken on each clock while req_ready is high, at link rate.
// Bytes are counted (saturating at 65535), header fields are captured and the
// header checksum is summed as they arrive. The transfer of the last byte
// produces one result on the rsp channel: the verdict, protocol, addresses,
// header length and payload length. Other bytes produce no result.
// From the last byte's transfer to rsp_valid the finished header state goes
// through one snapshot register, then through the verdict logic into the
// result register. Throughput is one byte per cycle while req_ready is high,
// and a new packet may begin on the cycle after a last byte.
// When the receiver stalls, the result is held and one further finished
// packet waits in the snapshot register; req_ready drops only when both are
// full and the result is not being taken. Reset clears the packet state,
// both pipeline stages and the host address and netmask registers (offsets 0, 4).
// ----------------------------------------------------------------------------
module ipv4_receive_header_filter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ihf_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ihf_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ihf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import ihf_pkg::*;

   cfg_type        cfg;
   pkt_fields_type fields_next;
   pkt_fields_type snap_ff;
   pkt_fields_type snap_in;
   logic           snap_valid_ff;
   logic           snap_valid_in;
   rsp_type        judge_rsp;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           req_take;
   logic           snap_load;
   logic           snap_advance;

   ihf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ihf_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .take        (req_take),
      .req         (req_data),
      .fields_next (fields_next)
   );

   ihf_judge u_judge (
      .fields (snap_ff),
      .cfg    (cfg),
      .rsp    (judge_rsp)
   );

   // Flow control through the snapshot and result stages.
   assign snap_advance = snap_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !snap_valid_ff || snap_advance;
   assign req_take     = req_valid && req_ready;
   assign snap_load    = req_take && req_data.last_byte;

   // Snapshot of the finished header state on the last byte.
   always_comb begin
      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff;
      if (snap_load) begin
         snap_in       = fields_next;
         snap_valid_in = 1'b1;
      end else if (snap_advance) begin
         snap_valid_in = 1'b0;
      end
   end

   // Result register, loaded when the snapshot moves on.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (snap_advance) begin
         rsp_in       = judge_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/ihf_csr.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header filter configuration registers
// APB-style register file holding the local address and the netmask.
// ----------------------------------------------------------------------------
module ihf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ihf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output ihf_pkg::cfg_type              cfg
);
   import ihf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite;

   // Register write in the access phase of a transfer.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            CSR_IDX_HOST_ADDR: cfg_in.host_addr = pwdata;
            CSR_IDX_NETMASK:   cfg_in.netmask   = pwdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data follows the address.
   always_comb begin
      case (reg_idx)
         CSR_IDX_HOST_ADDR: prdata = cfg_ff.host_addr;
         CSR_IDX_NETMASK:   prdata = cfg_ff.netmask;
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/ihf_accum.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header filter byte accumulator
// Counts packet bytes, captures header fields and keeps the header checksum.
// ----------------------------------------------------------------------------
module ihf_accum (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  ihf_pkg::req_type        req,
   output ihf_pkg::pkt_fields_type fields_next
);
   import ihf_pkg::*;

   pkt_fields_type fields_ff;
   pkt_fields_type fields_in;
   pkt_fields_type upd;
   logic [15:0]    idx;
   logic [7:0]     b;
   logic [5:0]     hlen;
   logic [16:0]    sum_wide;

   assign idx = fields_ff.byte_count;
   assign b   = req.data_byte;

   // Field capture and checksum update for the byte on the input.
   always_comb begin
      upd = fields_ff;
      if (idx == 16'd0) begin
         upd.version_ihl = b;
      end
      hlen = {upd.version_ihl[3:0], 2'b00};

      if (idx == 16'd2 || idx == 16'd3) begin
         upd.total_len = {fields_ff.total_len[7:0], b};
      end else if (idx == 16'd6 || idx == 16'd7) begin
         upd.frag = {fields_ff.frag[7:0], b};
      end else if (idx == 16'd9) begin
         upd.proto = b;
      end else if (idx >= 16'd12 && idx <= 16'd15) begin
         upd.source_addr = {fields_ff.source_addr[23:0], b};
      end else if (idx >= 16'd16 && idx <= 16'd19) begin
         upd.dest_addr = {fields_ff.dest_addr[23:0], b};
      end

      // Even bytes are held; odd bytes complete a word inside the header.
      sum_wide = {1'b0, fields_ff.header_sum} + {1'b0, fields_ff.held_byte, b};
      if (!idx[0]) begin
         upd.held_byte = b;
      end else if (idx < {10'd0, hlen}) begin
         upd.header_sum = sum_wide[15:0] + {15'd0, sum_wide[16]};
      end

      if (fields_ff.byte_count != COUNT_MAX) begin
         upd.byte_count = fields_ff.byte_count + 16'd1;
      end
   end

   // A packet's state clears once its last byte has been taken.
   always_comb begin
      fields_in = fields_ff;
      if (take) begin
         if (req.last_byte) begin
            fields_in = '0;
         end else begin
            fields_in = upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fields_ff <= '0;
      end else begin
         fields_ff <= fields_in;
      end
   end

   assign fields_next = upd;

endmodule

/* rtl/core/ihf_judge.sv */
// ----------------------------------------------------------------------------
// IPv4 receive header filter verdict logic
// Runs the ordered header checks and the address filter on a finished packet.
// ----------------------------------------------------------------------------
module ihf_judge (
   input  ihf_pkg::pkt_fields_type fields,
   input  ihf_pkg::cfg_type        cfg,
   output ihf_pkg::rsp_type        rsp
);
   import ihf_pkg::*;

   logic [3:0]  ver;
   logic [3:0]  ihl;
   logic [5:0]  hlen;
   logic [15:0] hlen16;
   logic [15:0] len;
   logic [15:0] tot;
   logic [31:0] dst;
   logic [7:0]  prot;
   logic        accept;
   logic        to_local;

   assign ver      = fields.version_ihl[7:4];
   assign ihl      = fields.version_ihl[3:0];
   assign hlen     = {ihl, 2'b00};
   assign hlen16   = {10'd0, hlen};
   assign len      = fields.byte_count;
   assign tot      = fields.total_len;
   assign dst      = fields.dest_addr;
   assign prot     = fields.proto;
   assign to_local = (dst == cfg.host_addr);

   // Address filter: local, limited broadcast, unconfigured UDP, directed broadcast.
   always_comb begin
      accept = 1'b0;
      if (to_local || dst == BCAST_ALL) begin
         accept = 1'b1;
      end else if (cfg.host_addr == 32'd0 && prot == PROTO_UDP) begin
         accept = 1'b1;
      end else if (cfg.netmask != 32'd0
                   && (dst & cfg.netmask) == (cfg.host_addr & cfg.netmask)
                   && (dst | cfg.netmask) == BCAST_ALL) begin
         accept = 1'b1;
      end
   end

   // Ordered checks, then dispatch on the protocol.
   always_comb begin
      rsp.protocol    = prot;
      rsp.src_ip      = fields.source_addr;
      rsp.dst_ip      = dst;
      rsp.header_len  = hlen;
      rsp.body_len    = '0;
      if (len < HDR_MIN_LEN) begin
         rsp.verdict = VERDICT_SHORT;
      end else if (ver != VERSION_FOUR || ihl < IHL_MIN) begin
         rsp.verdict = VERDICT_VERSION_IHL;
      end else if (hlen16 > len) begin
         rsp.verdict = VERDICT_HDR_PAST;
      end else if (tot < hlen16 || tot > len) begin
         rsp.verdict = VERDICT_TOTLEN;
      end else if ((fields.frag & FRAG_MASK) != 16'd0) begin
         rsp.verdict = VERDICT_FRAGMENT;
      end else if (fields.header_sum != SUM_GOOD) begin
         rsp.verdict = VERDICT_CHECKSUM;
      end else if (!accept) begin
         rsp.verdict = VERDICT_NOT_ADDR;
      end else if ((prot == PROTO_ICMP || prot == PROTO_TCP) && !to_local) begin
         rsp.verdict = VERDICT_NOT_LOCAL;
      end else begin
         rsp.body_len = tot - hlen16;
         if (prot == PROTO_ICMP) begin
            rsp.verdict = VERDICT_ICMP;
         end else if (prot == PROTO_UDP) begin
            rsp.verdict = VERDICT_UDP;
         end else if (prot == PROTO_TCP) begin
            rsp.verdict = VERDICT_TCP;
         end else begin
            rsp.verdict = VERDICT_NO_HANDLER;
         end
      end
   end

endmodule

/* sim/tb_ipv4_receive_header_filter_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the IPv4 receive header filter
// Streams IPv4 packets, broken headers and noise into the filter one byte
// per transfer and predicts the verdict of every packet on its own. Each
// result transfer is compared field by field with the oldest prediction.
// Both handshakes idle at random, and the address registers are reprogrammed
// between phases.
// ----------------------------------------------------------------------------
module tb_ipv4_receive_header_filter_unit;
   import ihf_pkg::*;

   // Predicts the verdict of each packet from the bytes that the filter takes.
   class header_verdict_predictor;
      logic [31:0]    host_addr;
      logic [31:0]    netmask;
      pkt_fields_type pkt;
      rsp_type        pending_verdicts[$];

      function new();
         host_addr = '0;
         netmask   = '0;
         pkt       = '0;
      endfunction

      function void set_register(input logic idx, input logic [31:0] value);
         if (idx == CSR_IDX_HOST_ADDR) begin
            host_addr = value;
         end else begin
            netmask = value;
         end
      endfunction

      // Checks in the filter's fixed order; payload length only on delivery.
      function verdict_type judge(output logic [15:0] plen);
         logic [15:0] hlen;
         logic [31:0] dst;
         logic [7:0]  prot;
         bit          accept;
         hlen   = {10'd0, pkt.version_ihl[3:0], 2'b00};
         dst    = pkt.dest_addr;
         prot   = pkt.proto;
         accept = 1'b0;
         plen   = '0;
         if (pkt.byte_count < HDR_MIN_LEN) return VERDICT_SHORT;
         if (pkt.version_ihl[7:4] != VERSION_FOUR || pkt.version_ihl[3:0] < IHL_MIN)
            return VERDICT_VERSION_IHL;
         if (hlen > pkt.byte_count) return VERDICT_HDR_PAST;
         if (pkt.total_len < hlen || pkt.total_len > pkt.byte_count) return VERDICT_TOTLEN;
         if ((pkt.frag & FRAG_MASK) != 0) return VERDICT_FRAGMENT;
         if (pkt.header_sum != SUM_GOOD) return VERDICT_CHECKSUM;

         // Address acceptance: own address, limited broadcast, any UDP while
         // unconfigured, or the subnet-directed broadcast.
         if (dst == host_addr || dst == BCAST_ALL) begin
            accept = 1'b1;
         end else if (host_addr == 0 && prot == PROTO_UDP) begin
            accept = 1'b1;
         end else if (netmask != 0 && (dst & netmask) == (host_addr & netmask) &&
                      (dst & ~netmask) == ~netmask) begin
            accept = 1'b1;
         end
         if (!accept) return VERDICT_NOT_ADDR;
         if ((prot == PROTO_ICMP || prot == PROTO_TCP) && dst != host_addr)
            return VERDICT_NOT_LOCAL;

         plen = pkt.total_len - hlen;
         if (prot == PROTO_ICMP) return VERDICT_ICMP;
         if (prot == PROTO_UDP) return VERDICT_UDP;
         if (prot == PROTO_TCP) return VERDICT_TCP;
         return VERDICT_NO_HANDLER;
      endfunction

      // Notes one accepted byte; the last byte of a buffer yields a verdict.
      function void absorb_byte(input req_type item);
         logic [7:0]  b;
         logic [15:0] idx;
         logic [15:0] hlen;
         logic [16:0] acc;
         logic [15:0] plen;
         rsp_type     res;
         b   = item.data_byte;
         idx = pkt.byte_count;
         if (idx == 0) pkt.version_ihl = b;
         hlen = {10'd0, pkt.version_ihl[3:0], 2'b00};

         // Field capture by byte position.
         if (idx == 2 || idx == 3) begin
            pkt.total_len = {pkt.total_len[7:0], b};
         end else if (idx == 6 || idx == 7) begin
            pkt.frag = {pkt.frag[7:0], b};
         end else if (idx == 9) begin
            pkt.proto = b;
         end else if (idx >= 12 && idx <= 15) begin
            pkt.source_addr = {pkt.source_addr[23:0], b};
         end else if (idx >= 16 && idx <= 19) begin
            pkt.dest_addr = {pkt.dest_addr[23:0], b};
         end

         // Ones' complement sum over header words, with end-around carry.
         if (!idx[0]) begin
            pkt.held_byte = b;
         end else if (idx < hlen) begin
            acc = {1'b0, pkt.header_sum} + {1'b0, pkt.held_byte, b};
            pkt.header_sum = acc[15:0] + {15'd0, acc[16]};
         end
         if (pkt.byte_count != COUNT_MAX) pkt.byte_count = pkt.byte_count + 16'd1;

         if (item.last_byte) begin
            res.verdict     = judge(plen);
            res.protocol    = pkt.proto;
            res.src_ip      = pkt.source_addr;
            res.dst_ip      = pkt.dest_addr;
            res.header_len  = {pkt.version_ihl[3:0], 2'b00};
            res.body_len    = plen;
            pending_verdicts.push_back(res);
            pkt = '0;
         end
      endfunction

      // Returns a description of every wrong field, or an empty string.
      function string compare_verdict(input rsp_type got);
         rsp_type want;
         string   msg;
         if (pending_verdicts.size() == 0)
            return $sformatf("verdict %0d arrived with none outstanding", got.verdict);
         want = pending_verdicts.pop_front();
         msg  = "";
         if (got.verdict != want.verdict)
            msg = {msg, $sformatf(" verdict got %0d want %0d", got.verdict, want.verdict)};
         if (got.protocol != want.protocol)
            msg = {msg, $sformatf(" protocol got %0d want %0d", got.protocol, want.protocol)};
         if (got.src_ip != want.src_ip)
            msg = {msg, $sformatf(" src_ip got %h want %h", got.src_ip, want.src_ip)};
         if (got.dst_ip != want.dst_ip)
            msg = {msg, $sformatf(" dst_ip got %h want %h", got.dst_ip, want.dst_ip)};
         if (got.header_len != want.header_len)
            msg = {msg, $sformatf(" header_len got %0d want %0d",
                                  got.header_len, want.header_len)};
         if (got.body_len != want.body_len)
            msg = {msg, $sformatf(" body_len got %0d want %0d",
                                  got.body_len, want.body_len)};
         return msg;
      endfunction
   endclass

   // Clock, reset and block ports, all known from time zero.
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   header_verdict_predictor pred;
   logic [7:0] frame[$];
   int         mismatch_count = 0;
   int         bytes_sent     = 0;
   int         verdicts_seen  = 0;
   int         req_mode       = 1;
   int         rsp_mode       = 1;
   int         hold_cycles    = 0;

   ipv4_receive_header_filter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch:%s", $time, what);
   endtask

   // Idle cycles before a transfer: none, occasional, or heavy.
   function automatic int draw_gap(input int mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
         default: return $urandom_range(0, 19);
      endcase
   endfunction

   // Watch both channels at the rising edge.
   always @(posedge clock) begin : watch
      string msg;
      if (!reset) begin
         if (req_valid && req_ready) pred.absorb_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            msg = pred.compare_verdict(rsp_data);
            if (msg.len() != 0) report_mismatch(msg);
         end
      end
   end

   // Receiver: random stalls per result, plus a long hold-off on request.
   initial begin : receiver
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         gap = draw_gap(rsp_mode);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // One byte transfer; entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = draw_gap(req_mode);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: value, last_byte: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Sends the first count bytes of the frame, marking the final one.
   task automatic send_frame(input int count);
      for (int i = 0; i < count; i++) send_byte(frame[i], i == count - 1);
   endtask

   // Builds a header with a correct checksum followed by random payload.
   function automatic void build_packet(input logic [3:0] ver, input logic [3:0] ihl,
                                        input logic [15:0] tot, input logic [15:0] frag,
                                        input logic [7:0] proto, input logic [31:0] src,
                                        input logic [31:0] dst, input int pay);
      int          hbytes;
      logic [16:0] acc;
      logic [15:0] sum;
      hbytes = (ihl >= IHL_MIN) ? ihl * 4 : 20;
      frame.delete();
      for (int i = 0; i < hbytes + pay; i++) frame.push_back(8'($urandom_range(0, 255)));
      frame[0]  = {ver, ihl};
      frame[2]  = tot[15:8];
      frame[3]  = tot[7:0];
      frame[6]  = frag[15:8];
      frame[7]  = frag[7:0];
      frame[9]  = proto;
      frame[10] = 8'h00;
      frame[11] = 8'h00;
      for (int i = 0; i < 4; i++) begin
         frame[12 + i] = src[31 - 8 * i -: 8];
         frame[16 + i] = dst[31 - 8 * i -: 8];
      end
      sum = '0;
      for (int i = 0; i < ihl * 4; i += 2) begin
         acc = {1'b0, sum} + {1'b0, frame[i], frame[i + 1]};
         sum = acc[15:0] + {15'd0, acc[16]};
      end
      {frame[10], frame[11]} = ~sum;
   endfunction

   // Register write on the configuration port, then a read back.
   task automatic program_register(input logic idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pred.set_register(idx, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value)
         report_mismatch($sformatf(" register %0d reads %h want %h", idx, prdata, value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Stops offering bytes and waits until every predicted verdict has been
   // taken, then a little more.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pred.pending_verdicts.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] addr, input logic [31:0] mask);
      wait_drain();
      program_register(CSR_IDX_HOST_ADDR, addr);
      program_register(CSR_IDX_NETMASK, mask);
   endtask

   function automatic logic [7:0] pick_proto();
      case ($urandom_range(0, 3))
         0: return PROTO_ICMP;
         1: return PROTO_TCP;
         2: return PROTO_UDP;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Destinations that hit each acceptance rule, and some that miss.
   function automatic logic [31:0] pick_dst();
      case ($urandom_range(0, 6))
         0, 1: return pred.host_addr;
         2: return BCAST_ALL;
         3: return (pred.host_addr & pred.netmask) | ~pred.netmask;
         4: return (pred.host_addr & pred.netmask) | ($urandom & ~pred.netmask);
         5: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // Settings for a random phase, the extremes among them.
   task automatic configure_random();
      case ($urandom_range(0, 5))
         0: configure(32'h0, 32'h0);
         1: configure($urandom, 32'hFFFF_FF00);
         2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
         3: configure($urandom, 32'hFFFF_FFFF << $urandom_range(1, 31));
         4: configure(32'h0, 32'hFFFF_0000);
         default: configure($urandom, $urandom);
      endcase
   endtask

   // Stimulus and end of run.
   initial begin : stimulus
      logic [3:0]  ver;
      logic [3:0]  ihl;
      logic [15:0] tot;
      logic [15:0] frag;
      int          hl;
      int          pay;
      int          cut;
      int          fault;
      int          pk;
      pred = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed packets under the reset configuration.
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h0, PROTO_UDP,
                   32'h0A00_0001, 32'h0A00_0002, 0);
      send_frame(1);
      send_frame(19);
      foreach (frame[i]) frame[i] = 8'h00;
      send_frame(20);
      build_packet(4'd6, IHL_MIN, 16'd20, 16'h0, PROTO_UDP, $urandom, $urandom, 0);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, 4'd4, 16'd20, 16'h0, PROTO_UDP, $urandom, $urandom, 0);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd23, 16'h0, PROTO_UDP,
                   $urandom, 32'h0B0C_0D0E, 3);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h0, PROTO_ICMP,
                   $urandom, 32'h0B0C_0D0E, 0);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h0, PROTO_ICMP, $urandom, BCAST_ALL, 0);
      send_frame(frame.size());

      // Directed packets with a configured host on a /24.
      configure(32'hC0A8_0105, 32'hFFFF_FF00);
      build_packet(VERSION_FOUR, IHL_MIN, 16'd28, 16'h0, PROTO_ICMP,
                   $urandom, 32'hC0A8_0105, 8);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h0, PROTO_UDP,
                   $urandom, 32'hC0A8_0105, 0);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd22, 16'h0, PROTO_TCP,
                   $urandom, 32'hC0A8_0105, 2);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd21, 16'h0, 8'h2F, $urandom, 32'hC0A8_0105, 1);
      send_frame(frame.size());
      // Header longer than the buffer.
      build_packet(VERSION_FOUR, 4'hF, 16'd60, 16'h0, PROTO_UDP, $urandom, 32'hC0A8_0105, 0);
      send_frame(40);
      // Total length below the header, then beyond the buffer.
      build_packet(VERSION_FOUR, IHL_MIN, 16'd19, 16'h0, PROTO_UDP,
                   $urandom, 32'hC0A8_0105, 4);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd25, 16'h0, PROTO_UDP,
                   $urandom, 32'hC0A8_0105, 4);
      send_frame(frame.size());
      // More fragments, the flag bits outside the mask, and a full offset.
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h2000, PROTO_UDP,
                   $urandom, 32'hC0A8_0105, 0);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'hC000, PROTO_UDP,
                   $urandom, 32'hC0A8_0105, 0);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h1FFF, PROTO_UDP,
                   $urandom, 32'hC0A8_0105, 0);
      send_frame(frame.size());
      // Corrupted checksum.
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h0, PROTO_UDP,
                   $urandom, 32'hC0A8_0105, 0);
      frame[10] = frame[10] ^ 8'h01;
      send_frame(frame.size());
      // Foreign address, then the subnet broadcast for UDP and for TCP.
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h0, PROTO_UDP,
                   $urandom, 32'h0A01_0203, 0);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h0, PROTO_UDP,
                   $urandom, 32'hC0A8_01FF, 0);
      send_frame(frame.size());
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h0, PROTO_TCP,
                   $urandom, 32'hC0A8_01FF, 0);
      send_frame(frame.size());
      // Field extremes: widest header, all-ones addresses and payload.
      build_packet(VERSION_FOUR, 4'hF, 16'd68, 16'h0, 8'hFF, 32'hFFFF_FFFF, BCAST_ALL, 8);
      for (int i = 60; i < 68; i++) frame[i] = 8'hFF;
      send_frame(frame.size());
      // All-ones address and mask.
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      build_packet(VERSION_FOUR, IHL_MIN, 16'd20, 16'h0, PROTO_ICMP, $urandom, BCAST_ALL, 0);
      send_frame(frame.size());

      // Random packets: mostly well formed, the rest broken or noise.
      verdicts_seen = 0;
      pk            = 0;
      while (bytes_sent < 1850 || verdicts_seen < 60) begin
         if (pk % 20 == 0) configure_random();
         if (pk % 8 == 0) begin
            req_mode = $urandom_range(0, 2);
            rsp_mode = $urandom_range(0, 2);
         end

         // Long receiver hold-off while single-byte buffers keep coming,
         // so that the filter fills and stalls its input.
         if (pk == 10) begin
            wait_drain();
            req_mode    = 0;
            hold_cycles = 300;
            for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)), 1'b1);
         end

         fault = ($urandom_range(0, 99) < 62) ? -1 : $urandom_range(0, 8);
         ver   = VERSION_FOUR;
         ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : IHL_MIN;
         frag  = {2'($urandom_range(0, 3)), 14'd0};
         if (fault == 1) ver = 4'($urandom_range(0, 15));
         if (fault == 2) ihl = 4'($urandom_range(0, 4));
         if (fault == 3) ihl = 4'($urandom_range(6, 15));
         if (fault == 6) frag = 16'($urandom_range(0, 65535));
         hl  = (ihl >= IHL_MIN) ? ihl * 4 : 20;
         pay = $urandom_range(0, 12);
         tot = 16'(hl + pay);
         if (fault == 4) tot = 16'($urandom_range(0, hl - 1));
         if (fault == 5) begin
            tot = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                              : 16'(hl + pay + $urandom_range(1, 300));
         end
         build_packet(ver, ihl, tot, frag, pick_proto(), $urandom, pick_dst(), pay);
         cut = frame.size();

         case (fault)
            0: cut = $urandom_range(1, 19);
            3: cut = $urandom_range(20, hl - 1);
            7: begin
               cut = $urandom_range(1, hl - 1);
               frame[cut] = frame[cut] ^ 8'($urandom_range(1, 255));
               cut = frame.size();
            end
            8: begin
               frame.delete();
               cut = $urandom_range(1, 48);
               for (int i = 0; i < cut; i++) frame.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
         endcase
         send_frame(cut);
         pk++;
      end

      // Drain and finish.
      req_valid <= 1'b0;
      while (pred.pending_verdicts.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (pred.pending_verdicts.size() != 0)
         report_mismatch($sformatf(" %0d verdicts never arrived", pred.pending_verdicts.size()));
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
